[hw/rtl/aprr_pkg.sv]
// shared types and constants for the advertising packet parser and rssi radar
`default_nettype none
package aprr_pkg;

   localparam int PKT_BYTES_DEF = 18;
   localparam int PKT_VIEW      = 18;
   localparam int HDR_BYTES     = 8;

   localparam logic [7:0] MAGIC_A       = 8'hB6;
   localparam logic [7:0] MAGIC_B       = 8'hD3;
   localparam logic [7:0] PROTO_VERSION = 8'h01;
   localparam logic [7:0] MFG_TYPE      = 8'hFF;

   localparam logic signed [7:0] LOST_RSSI = -8'sd127;
   localparam logic signed [7:0] LVL0_MAX  = -8'sd70;
   localparam logic signed [7:0] LVL1_MAX  = -8'sd62;
   localparam logic signed [7:0] LVL2_MAX  = -8'sd54;
   localparam logic signed [7:0] LVL3_MAX  = -8'sd46;
   localparam logic signed [7:0] LVL4_MAX  = -8'sd40;

   localparam logic [31:0] STALE_TIME_RST = 32'd3000000;

   typedef enum logic [3:0] {
      PH_LEN   = 4'b0001,
      PH_TYPE  = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_REQUEST = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_RESULT  = 2'd2,
      KIND_REPORT  = 2'd3
   } out_kind_type;

   typedef enum logic [2:0] {
      CSR_OWN_IDENTITY = 3'd0,
      CSR_STALE_TIME   = 3'd1,
      CSR_CODE_BEACON  = 3'd2,
      CSR_CODE_REQUEST = 3'd3,
      CSR_CODE_ACK     = 3'd4,
      CSR_CODE_RESULT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ad_byte;
      logic        last_byte;
      logic signed [7:0] report_rssi;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [31:0] sender;
      logic signed [7:0] event_rssi;
      logic [31:0] first_word;
      logic [31:0] second_word;
      logic [15:0] short_value;
      logic [7:0]  ok_byte;
      logic [2:0]  level;
      logic [31:0] host;
      logic [7:0]  host_species;
      logic signed [7:0] filtered_rssi;
   } rsp_type;

   typedef struct packed {
      logic [31:0] own_identity;
      logic [31:0] stale_time_us;
      logic [7:0]  code_beacon;
      logic [7:0]  code_catch_request;
      logic [7:0]  code_catch_ack;
      logic [7:0]  code_catch_result;
   } cfg_type;

   typedef struct packed {
      logic       found;
      logic       done;
      logic [7:0] field_length;
   } parse_status_type;

endpackage
`default_nettype wire

[hw/rtl/adv_packet_parser_rssi_radar.sv]
// top level of the advertising packet parser and rssi radar
// One item (an advertising data byte or a radar query) is taken every clock
// cycle while req_stall is low. An accepted item sits in the input register
// while the element walker, the header decode and the rssi averaging update
// work on it, and its result, if any, then moves into the result register,
// which drives rsp_valid. The rate of one item per cycle holds while the
// result register is not stalled; a stalled result register holds the input
// stage only when an item is waiting behind it. Only the first
// manufacturer-data element of a report is decoded, and a packet is handled
// on the report's last byte. Configuration writes are always ready.
`default_nettype none
module adv_packet_parser_rssi_radar import aprr_pkg::*; #(
   parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire logic [7:0]        req_ad_byte,
   input  wire logic              req_last_byte,
   input  wire logic signed [7:0] req_report_rssi,
   input  wire logic [47:0]       req_now_us,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_out_kind,
   output logic [31:0]            rsp_sender,
   output logic signed [7:0]      rsp_event_rssi,
   output logic [31:0]            rsp_first_word,
   output logic [31:0]            rsp_second_word,
   output logic [15:0]            rsp_short_value,
   output logic [7:0]             rsp_ok_byte,
   output logic [2:0]             rsp_level,
   output logic [31:0]            rsp_host,
   output logic [7:0]             rsp_host_species,
   output logic signed [7:0]      rsp_filtered_rssi,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   cfg_type cfg_ff;

   logic    accept, advance;
   logic    byte_step, beacon_step, has_result;

   parse_status_type status;
   logic [7:0]       pkt [PACKET_BYTES];
   logic             beacon_hit, event_hit;
   logic [31:0]      sender;
   logic [7:0]       species;
   rsp_type          event_item, report;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.kind        <= req_kind;
         in_item_ff.ad_byte     <= req_ad_byte;
         in_item_ff.last_byte   <= req_last_byte;
         in_item_ff.report_rssi <= req_report_rssi;
         in_item_ff.now_us      <= req_now_us;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_identity       <= 32'd0;
         cfg_ff.stale_time_us      <= STALE_TIME_RST;
         cfg_ff.code_beacon        <= 8'd0;
         cfg_ff.code_catch_request <= 8'd1;
         cfg_ff.code_catch_ack     <= 8'd2;
         cfg_ff.code_catch_result  <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OWN_IDENTITY: cfg_ff.own_identity       <= csr_wdata;
            CSR_STALE_TIME:   cfg_ff.stale_time_us      <= csr_wdata;
            CSR_CODE_BEACON:  cfg_ff.code_beacon        <= csr_wdata[7:0];
            CSR_CODE_REQUEST: cfg_ff.code_catch_request <= csr_wdata[7:0];
            CSR_CODE_ACK:     cfg_ff.code_catch_ack     <= csr_wdata[7:0];
            CSR_CODE_RESULT:  cfg_ff.code_catch_result  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign byte_step   = advance && !in_item_ff.kind;
   assign beacon_step = byte_step && in_item_ff.last_byte && beacon_hit;

   aprr_parser #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (byte_step),
      .last_byte (in_item_ff.last_byte),
      .ad_byte   (in_item_ff.ad_byte),
      .status    (status),
      .pkt       (pkt)
   );

   aprr_packet #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_packet (
      .status     (status),
      .pkt        (pkt),
      .cfg        (cfg_ff),
      .rssi       (in_item_ff.report_rssi),
      .beacon_hit (beacon_hit),
      .event_hit  (event_hit),
      .sender     (sender),
      .species    (species),
      .event_item (event_item)
   );

   aprr_radar u_radar (
      .clock          (clock),
      .reset          (reset),
      .beacon_step    (beacon_step),
      .rssi           (in_item_ff.report_rssi),
      .now_us         (in_item_ff.now_us),
      .stale_time_us  (cfg_ff.stale_time_us),
      .beacon_sender  (sender),
      .beacon_species (species),
      .report         (report)
   );

   assign has_result  = in_item_ff.kind || (in_item_ff.last_byte && event_hit);
   assign out_item_in = in_item_ff.kind ? report : event_item;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = has_result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_kind      = out_item_ff.out_kind;
   assign rsp_sender        = out_item_ff.sender;
   assign rsp_event_rssi    = out_item_ff.event_rssi;
   assign rsp_first_word    = out_item_ff.first_word;
   assign rsp_second_word   = out_item_ff.second_word;
   assign rsp_short_value   = out_item_ff.short_value;
   assign rsp_ok_byte       = out_item_ff.ok_byte;
   assign rsp_level         = out_item_ff.level;
   assign rsp_host          = out_item_ff.host;
   assign rsp_host_species  = out_item_ff.host_species;
   assign rsp_filtered_rssi = out_item_ff.filtered_rssi;

endmodule
`default_nettype wire

[hw/rtl/aprr_parser.sv]
// ad element walker and packet byte store
`default_nettype none
module aprr_parser import aprr_pkg::*; #(
   parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             last_byte,
   input  wire logic [7:0]       ad_byte,
   output parse_status_type      status,
   output logic [7:0]            pkt [PACKET_BYTES]
);

   localparam int IDX_W = $clog2(PACKET_BYTES);

   phase_type   phase_ff, phase_in, phase_tb;
   logic [7:0]  rem_ff, rem_in, rem_tb;
   logic        found_ff, found_in, found_tb;
   logic [7:0]  flen_ff, flen_in, flen_tb;
   logic [7:0]  store_ff [PACKET_BYTES];
   logic [7:0]  store_in [PACKET_BYTES];
   logic [7:0]  pos;
   logic [7:0]  wr_pos;
   logic        wr_en;

   always_comb begin
      phase_tb = phase_ff;
      rem_tb   = rem_ff;
      found_tb = found_ff;
      flen_tb  = flen_ff;
      wr_en    = 1'b0;
      pos      = flen_ff - 8'd1 - rem_ff;
      wr_pos   = pos - 8'd2;
      case (phase_ff)
         PH_LEN: begin
            if (ad_byte != 8'd0) begin
               rem_tb   = ad_byte;
               phase_tb = PH_TYPE;
            end
         end
         PH_TYPE: begin
            rem_tb = rem_ff - 8'd1;
            if (ad_byte == MFG_TYPE) begin
               found_tb = 1'b1;
               flen_tb  = rem_ff;
               phase_tb = (rem_tb == 8'd0) ? PH_DONE : PH_VALUE;
            end else begin
               phase_tb = (rem_tb == 8'd0) ? PH_LEN : PH_VALUE;
            end
         end
         PH_VALUE: begin
            wr_en  = found_ff && (pos >= 8'd2) && (wr_pos < 8'(PACKET_BYTES));
            rem_tb = rem_ff - 8'd1;
            if (rem_tb == 8'd0) begin
               phase_tb = found_ff ? PH_DONE : PH_LEN;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      store_in = store_ff;
      if (wr_en) begin
         store_in[wr_pos[IDX_W-1:0]] = ad_byte;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      found_in = found_ff;
      flen_in  = flen_ff;
      if (step) begin
         if (last_byte) begin
            phase_in = PH_LEN;
            rem_in   = 8'd0;
            found_in = 1'b0;
            flen_in  = 8'd0;
         end else begin
            phase_in = phase_tb;
            rem_in   = rem_tb;
            found_in = found_tb;
            flen_in  = flen_tb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         rem_ff   <= 8'd0;
         found_ff <= 1'b0;
         flen_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         found_ff <= found_in;
         flen_ff  <= flen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         store_ff <= store_in;
      end
   end

   assign status.found        = found_tb;
   assign status.done         = (phase_tb == PH_DONE);
   assign status.field_length = flen_tb;
   assign pkt                 = store_in;

endmodule
`default_nettype wire

[hw/rtl/aprr_packet.sv]
// header check and event decode of a captured packet
`default_nettype none
module aprr_packet import aprr_pkg::*; #(
   parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
   input  parse_status_type      status,
   input  wire logic [7:0]       pkt [PACKET_BYTES],
   input  cfg_type               cfg,
   input  wire logic signed [7:0] rssi,
   output logic                  beacon_hit,
   output logic                  event_hit,
   output logic [31:0]           sender,
   output logic [7:0]            species,
   output rsp_type               event_item
);

   localparam logic [7:0] MIN_HDR     = 8'(3 + HDR_BYTES);
   localparam logic [7:0] MIN_BEACON  = 8'(3 + HDR_BYTES + 2);
   localparam logic [7:0] MIN_REQUEST = 8'(3 + HDR_BYTES + 8);
   localparam logic [7:0] MIN_ACK     = 8'(3 + HDR_BYTES + 10);
   localparam logic [7:0] MIN_RESULT  = 8'(3 + HDR_BYTES + 7);

   logic [7:0] v [PKT_VIEW];
   logic [7:0] ptype;
   logic       hdr_ok;
   logic       is_beacon, is_req, is_ack, is_res;
   logic       req_hit, ack_hit, res_hit;
   logic [31:0] word8, word12;

   for (genvar i = 0; i < PKT_VIEW; i++) begin : g_view
      if (i < PACKET_BYTES) begin : g_have
         assign v[i] = pkt[i];
      end else begin : g_zero
         assign v[i] = 8'd0;
      end
   end

   assign ptype   = v[3];
   assign sender  = {v[7], v[6], v[5], v[4]};
   assign species = v[8];
   assign word8   = {v[11], v[10], v[9], v[8]};
   assign word12  = {v[15], v[14], v[13], v[12]};

   assign hdr_ok = status.found && status.done && (status.field_length >= MIN_HDR)
                   && (v[0] == MAGIC_A) && (v[1] == MAGIC_B) && (v[2] == PROTO_VERSION)
                   && (sender != cfg.own_identity);

   assign is_beacon = (ptype == cfg.code_beacon);
   assign is_req    = !is_beacon && (ptype == cfg.code_catch_request);
   assign is_ack    = !is_beacon && !is_req && (ptype == cfg.code_catch_ack);
   assign is_res    = !is_beacon && !is_req && !is_ack && (ptype == cfg.code_catch_result);

   assign beacon_hit = hdr_ok && is_beacon && (status.field_length >= MIN_BEACON);
   assign req_hit    = hdr_ok && is_req && (status.field_length >= MIN_REQUEST);
   assign ack_hit    = hdr_ok && is_ack && (status.field_length >= MIN_ACK);
   assign res_hit    = hdr_ok && is_res && (status.field_length >= MIN_RESULT);
   assign event_hit  = req_hit || ack_hit || res_hit;

   always_comb begin
      event_item            = '0;
      event_item.sender     = sender;
      event_item.event_rssi = rssi;
      event_item.first_word = word8;
      if (ack_hit) begin
         event_item.out_kind    = KIND_ACK;
         event_item.second_word = word12;
         event_item.short_value = {v[17], v[16]};
      end else if (res_hit) begin
         event_item.out_kind    = KIND_RESULT;
         event_item.short_value = {v[14], v[13]};
         event_item.ok_byte     = v[12];
      end else begin
         event_item.out_kind    = KIND_REQUEST;
         event_item.second_word = word12;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/aprr_radar.sv]
// radar state: beacon averaging, staleness and level report
`default_nettype none
module aprr_radar import aprr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beacon_step,
   input  wire logic signed [7:0] rssi,
   input  wire logic [47:0]       now_us,
   input  wire logic [31:0]       stale_time_us,
   input  wire logic [31:0]       beacon_sender,
   input  wire logic [7:0]        beacon_species,
   output rsp_type                report
);

   localparam logic [10:0] RECIP_10    = 11'd1639;
   localparam int          RECIP_SHIFT = 14;

   logic signed [7:0] avg_ff, avg_in;
   logic [47:0]       seen_ff;
   logic [31:0]       host_ff;
   logic [7:0]        species_ff;

   logic [47:0]       age;
   logic              stale;
   logic signed [11:0] sum;
   logic [10:0]       mag;
   logic [21:0]       prod;
   logic [7:0]        quot;
   logic signed [7:0] avg_mix;
   logic signed [7:0] r;
   logic [2:0]        lvl;

   assign age   = now_us - seen_ff;
   assign stale = (now_us > seen_ff) && (age > {16'd0, stale_time_us});

   assign sum     = 12'(avg_ff) * 12'sd7 + 12'(rssi) * 12'sd3;
   assign mag     = sum[11] ? 11'(-sum) : 11'(sum);
   assign prod    = 22'(mag) * 22'(RECIP_10);
   assign quot    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
   assign avg_mix = sum[11] ? -quot : quot;
   assign avg_in  = stale ? rssi : avg_mix;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff     <= LOST_RSSI;
         seen_ff    <= 48'd0;
         host_ff    <= 32'd0;
         species_ff <= 8'd0;
      end else if (beacon_step) begin
         avg_ff     <= avg_in;
         seen_ff    <= now_us;
         host_ff    <= beacon_sender;
         species_ff <= beacon_species;
      end
   end

   assign r = stale ? LOST_RSSI : avg_ff;

   always_comb begin
      if (r <= LVL0_MAX) begin
         lvl = 3'd0;
      end else if (r <= LVL1_MAX) begin
         lvl = 3'd1;
      end else if (r <= LVL2_MAX) begin
         lvl = 3'd2;
      end else if (r <= LVL3_MAX) begin
         lvl = 3'd3;
      end else if (r <= LVL4_MAX) begin
         lvl = 3'd4;
      end else begin
         lvl = 3'd5;
      end
   end

   always_comb begin
      report               = '0;
      report.out_kind      = KIND_REPORT;
      report.level         = lvl;
      report.host          = (lvl != 3'd0) ? host_ff : 32'd0;
      report.host_species  = (lvl != 3'd0) ? species_ff : 8'd0;
      report.filtered_rssi = r;
   end

endmodule
`default_nettype wire
